### sv/kped_pkg.sv
// ----------------------------------------------------------------------------
// kped_pkg
// Shared types and constants of the key press event detector: field widths,
// default parameter values, register indexes and reset values, and the event
// mask layout.
// ----------------------------------------------------------------------------
`default_nettype none

package kped_pkg;

  // Fixed field widths of the stream payloads and the configuration port.
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned EV_W      = 8;
  localparam int unsigned PCNT_W    = 4;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_W      = 8;   // key_index + level, padded to a byte
  localparam int unsigned OUT_W     = 16;  // out_key + events + press tally

  // Default parameter values.
  localparam int unsigned NUM_KEYS_DEF        = 16;
  localparam int unsigned MAX_PRESS_COUNT_DEF = 15;
  localparam int unsigned TICK_LIMIT_DEF      = 65535;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_TMOUT = 2'd2;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd2;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd100;
  localparam logic [CFG_W-1:0] MULTI_TMOUT_RST = 16'd30;

  // Event mask, bit 0 (press) in the lowest position.
  typedef struct packed {
    logic release_timeout;
    logic press_timeout;
    logic long_release;
    logic long_press;
    logic multi_release;
    logic release_ev;
    logic multi_press;
    logic press;
  } kped_ev_t;

  // Shared timing registers as seen by the per-key update logic.
  typedef struct packed {
    logic [CFG_W-1:0] settle_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] multi_press_timeout;
  } kped_cfg_t;

endpackage : kped_pkg

`default_nettype wire

### sv/kped_key_step.sv
// ----------------------------------------------------------------------------
// kped_key_step
// Next-state and event logic for one scan tick of one key: gap timeout,
// debounce, press counting, hold timing and long press, release kinds.
// ----------------------------------------------------------------------------
`default_nettype none

module kped_key_step
  import kped_pkg::*;
#(
  parameter int unsigned TICK_W          = 16,
  parameter int unsigned CNT_W           = 4,
  parameter int unsigned MAX_PRESS_COUNT = MAX_PRESS_COUNT_DEF,
  parameter int unsigned TICK_LIMIT      = TICK_LIMIT_DEF
) (
  input  wire kped_cfg_t         cfg,
  input  wire logic              level,
  input  wire logic              pressed,
  input  wire logic [TICK_W-1:0] hold,
  input  wire logic [TICK_W-1:0] gap,
  input  wire logic [CNT_W-1:0]  cnt,
  input  wire logic              long_fired,
  output logic              pressed_nxt,
  output logic [TICK_W-1:0] hold_nxt,
  output logic [TICK_W-1:0] gap_nxt,
  output logic [CNT_W-1:0]  cnt_nxt,
  output logic              long_fired_nxt,
  output kped_ev_t          events,
  output logic [CNT_W-1:0]  cnt_report
);

  localparam logic [TICK_W-1:0] TICK_MAX = TICK_W'(TICK_LIMIT);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_PRESS_COUNT);
  localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);

  logic [TICK_W-1:0] gap_inc;
  logic [TICK_W-1:0] hold_inc;
  logic [CNT_W-1:0]  cnt_inc;
  logic              timeout;

  // Saturating increments.
  assign gap_inc  = (gap < TICK_MAX) ? gap + TICK_W'(1) : gap;
  assign hold_inc = (hold < TICK_MAX) ? hold + TICK_W'(1) : hold;
  assign cnt_inc  = (cnt < CNT_MAX) ? cnt + CNT_ONE : cnt;

  // Multi-press gap timing runs only while a press sequence is open.
  assign timeout = (cnt != '0) && (CFG_W'(gap_inc) >= cfg.multi_press_timeout);

  always_comb begin
    logic [CNT_W-1:0] cnt_mid;
    pressed_nxt    = pressed;
    hold_nxt       = hold;
    long_fired_nxt = long_fired;
    cnt_mid        = cnt;
    events         = '0;

    // Gap counter, cleared when the sequence times out.
    if (cnt != '0) begin
      gap_nxt = timeout ? '0 : gap_inc;
    end else begin
      gap_nxt = gap;
    end
    events.press_timeout   = timeout & pressed;
    events.release_timeout = timeout & ~pressed;

    if (!pressed) begin
      // Debounce: count pressed readings until the threshold is reached.
      if (level) begin
        if (CFG_W'(hold) >= cfg.settle_ticks) begin
          pressed_nxt = 1'b1;
          hold_nxt    = '0;
          gap_nxt     = '0;
          cnt_mid     = cnt_inc;
          if (cnt_inc > CNT_ONE) begin
            events.multi_press = 1'b1;
          end else begin
            events.press = 1'b1;
          end
        end else begin
          hold_nxt = hold_inc;
        end
      end
    end else begin
      // Held key: time the hold, report the kind of release.
      if (!level) begin
        pressed_nxt = 1'b0;
        hold_nxt    = '0;
        if (long_fired) begin
          long_fired_nxt      = 1'b0;
          events.long_release = 1'b1;
        end else if (cnt > CNT_ONE) begin
          events.multi_release = 1'b1;
        end else begin
          events.release_ev = 1'b1;
        end
      end else begin
        hold_nxt = hold_inc;
        if (CFG_W'(hold_inc) == cfg.long_press_ticks) begin
          long_fired_nxt    = 1'b1;
          events.long_press = 1'b1;
        end
      end
    end

    // The count is reported before a timeout clears it.
    cnt_report = cnt_mid;
    cnt_nxt    = timeout ? '0 : cnt_mid;
  end

endmodule : kped_key_step

`default_nettype wire

### sv/key_press_event_detector_core.sv
// ----------------------------------------------------------------------------
// key_press_event_detector_core
// Debounce, multi-press, long-press and timeout detection for a bank of keys
// scanned one tick at a time, with per-key state held in registers.
//
//   Channel   Direction  Payload (low bit first)
//   in_*      slave      key_index[3:0], level[4], zero pad to 8 bits
//   out_*     master     out_key[3:0], events[11:4], press_tally[15:12]
//   cfg_*     write      cfg_addr selects register, cfg_wdata 16 bits
//
// One scan tick is accepted per cycle while the output is not stalled. The
// per-key read-modify-write is done from the input register, and the result
// is written into the output register. Reset (rst_n low, synchronous) clears
// all key state and loads the register defaults. A stalled output holds its
// result; the input keeps accepting as long as the result ahead can move.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_event_detector_core
  import kped_pkg::*;
#(
  parameter int unsigned NUM_KEYS        = NUM_KEYS_DEF,        // 1 to 16
  parameter int unsigned MAX_PRESS_COUNT = MAX_PRESS_COUNT_DEF, // 1 to 15
  parameter int unsigned TICK_LIMIT      = TICK_LIMIT_DEF       // 255 to 65535
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Scan tick input
  input  wire logic                 in_tvalid,
  output      logic                 in_tready,
  input  wire logic [IN_W-1:0]      in_tdata,   // key_index[3:0], level[4]
  // Event result output
  output      logic                 out_tvalid,
  input  wire logic                 out_tready,
  // out_key[3:0], events[11:4], press_tally[15:12]
  output      logic [OUT_W-1:0]     out_tdata,
  // Configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned TICK_W = $clog2(TICK_LIMIT + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_PRESS_COUNT + 1);

  // Configuration registers.
  kped_cfg_t cfg_r;

  // Per-key state.
  logic              pressed_r    [NUM_KEYS];
  logic [TICK_W-1:0] hold_r       [NUM_KEYS];
  logic [TICK_W-1:0] gap_r        [NUM_KEYS];
  logic [CNT_W-1:0]  cnt_r        [NUM_KEYS];
  logic              long_fired_r [NUM_KEYS];

  // Input and output registers.
  logic              in_valid_r;
  logic [KEY_W-1:0]  in_key_r;
  logic              in_level_r;
  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  kped_ev_t          out_events_r;
  logic [PCNT_W-1:0] out_pcnt_r;

  logic              fire;
  logic              out_free;
  logic              in_range;
  logic [KEY_AW-1:0] idx;

  logic              pressed_nxt;
  logic [TICK_W-1:0] hold_nxt;
  logic [TICK_W-1:0] gap_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              long_fired_nxt;
  kped_ev_t          step_events;
  logic [CNT_W-1:0]  cnt_report;

  // Handshake: the tick in the input register moves whenever the output
  // register is empty or being drained.
  assign out_free  = ~out_valid_r | out_tready;
  assign fire      = in_valid_r & out_free;
  assign in_tready = ~in_valid_r | fire;

  assign in_range = (int'(in_key_r) < NUM_KEYS);
  assign idx      = in_key_r[KEY_AW-1:0];

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks        <= DEBOUNCE_RST;
      cfg_r.long_press_ticks    <= LONG_PRESS_RST;
      cfg_r.multi_press_timeout <= MULTI_TMOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE:    cfg_r.settle_ticks        <= cfg_wdata;
        REG_LONG_PRESS:  cfg_r.long_press_ticks    <= cfg_wdata;
        REG_MULTI_TMOUT: cfg_r.multi_press_timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_key_r   <= in_tdata[KEY_W-1:0];
      in_level_r <= in_tdata[KEY_W];
    end
  end

  // Update logic for the addressed key.
  kped_key_step #(
    .TICK_W          (TICK_W),
    .CNT_W           (CNT_W),
    .MAX_PRESS_COUNT (MAX_PRESS_COUNT),
    .TICK_LIMIT      (TICK_LIMIT)
  ) u_step (
    .cfg            (cfg_r),
    .level          (in_level_r),
    .pressed        (pressed_r[idx]),
    .hold           (hold_r[idx]),
    .gap            (gap_r[idx]),
    .cnt            (cnt_r[idx]),
    .long_fired     (long_fired_r[idx]),
    .pressed_nxt    (pressed_nxt),
    .hold_nxt       (hold_nxt),
    .gap_nxt        (gap_nxt),
    .cnt_nxt        (cnt_nxt),
    .long_fired_nxt (long_fired_nxt),
    .events         (step_events),
    .cnt_report     (cnt_report)
  );

  // Per-key state write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        pressed_r[i]    <= 1'b0;
        hold_r[i]       <= '0;
        gap_r[i]        <= '0;
        cnt_r[i]        <= '0;
        long_fired_r[i] <= 1'b0;
      end
    end else if (fire && in_range) begin
      pressed_r[idx]    <= pressed_nxt;
      hold_r[idx]       <= hold_nxt;
      gap_r[idx]        <= gap_nxt;
      cnt_r[idx]        <= cnt_nxt;
      long_fired_r[idx] <= long_fired_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_key_r    <= in_key_r;
      out_events_r <= in_range ? step_events : '0;
      out_pcnt_r   <= in_range ? PCNT_W'(cnt_report) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pcnt_r, out_events_r, out_key_r};

endmodule : key_press_event_detector_core

`default_nettype wire

### sv/kped_checker.sv
// ----------------------------------------------------------------------------
// kped_checker
// Port-level checks of the key press event detector: reset behavior, output
// stability under stall, and consistency of the reported event mask.
// ----------------------------------------------------------------------------
`default_nettype none

module kped_checker
  import kped_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  kped_ev_t ev;
  logic [PCNT_W-1:0] pcnt;

  assign ev   = out_tdata[KEY_W +: EV_W];
  assign pcnt = out_tdata[KEY_W+EV_W +: PCNT_W];

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // No result comes out right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Press, release and long press belong to different key phases.
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({ev.press | ev.multi_press,
                             ev.release_ev | ev.multi_release | ev.long_release,
                             ev.long_press}) &&
                   $onehot0({ev.press, ev.multi_press}) &&
                   $onehot0({ev.release_ev, ev.multi_release, ev.long_release}))
    else $error("conflicting press and release events");

  // A timeout is reported either while pressed or while released, not both.
  a_timeout_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({ev.press_timeout, ev.release_timeout}))
    else $error("both timeout kinds reported");

  // A single press always opens a sequence with a count of one.
  a_single_press_tally: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ev.press |-> pcnt == PCNT_W'(1))
    else $error("single press with wrong press count");

endmodule : kped_checker

bind key_press_event_detector_core kped_checker u_kped_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
